FILE: hw/rtl/srd_pkg.sv
// Shared types, codes and reset constants for the radix digit converter.
package srd_pkg;

	localparam int unsigned MAX_RADIX   = 16;
	localparam int unsigned STACK_DEPTH = 32;

	localparam logic [7:0]  CH_PLUS  = 8'd43;
	localparam logic [7:0]  CH_MINUS = 8'd45;

	localparam logic [1:0]  CFG_RADIX       = 2'd0;
	localparam logic [1:0]  CFG_DIGITS_LOW  = 2'd1;
	localparam logic [1:0]  CFG_DIGITS_HIGH = 2'd2;

	localparam logic [4:0]  RADIX_RST       = 5'd10;
	localparam logic [63:0] DIGITS_LOW_RST  = 64'h3736_3534_3332_3130;
	localparam logic [63:0] DIGITS_HIGH_RST = 64'h4645_4443_4241_3938;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_SIGN,
		ST_EMIT,
		ST_ERR
	} state_t;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_SIGN,
		EM_DIGIT,
		EM_ERR
	} emit_t;

	typedef struct packed {
		logic  load;
		logic  dig_start;
		logic  div_step;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic alpha_ok;
		logic neg;
		logic byte_last;
		logic quo_zero;
		logic last_digit;
		logic stack_empty;
		logic out_free;
	} status_t;

endpackage

FILE: hw/rtl/srd_ctrl.sv
// Sequencer for the radix digit converter: check, divide, then emit.
module srd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  srd_pkg::status_t st,
	output srd_pkg::cmd_t    cmd
);
	import srd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = st.alpha_ok ? ST_DIV : ST_ERR;
			end
			ST_DIV: begin
				if (st.byte_last && st.quo_zero) begin
					state_d = st.neg ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (st.out_free) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (st.out_free && st.last_digit) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		item_ready    = 1'b0;
		cmd.load      = 1'b0;
		cmd.dig_start = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.emit      = EM_NONE;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
			end
			ST_START: begin
				cmd.dig_start = st.alpha_ok;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_SIGN: begin
				if (st.out_free) begin
					cmd.emit = EM_SIGN;
				end
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit = EM_DIGIT;
				end
			end
			ST_ERR: begin
				if (st.out_free) begin
					cmd.emit = EM_ERR;
				end
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/srd_dp.sv
// Datapath: config registers, alphabet check, byte-serial divider, digit stack, output word.
module srd_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	input  logic signed [31:0]  value,
	input  logic                char_ready,
	output logic                char_valid,
	output logic [7:0]          out_char,
	output logic                last_char,
	output logic                alphabet_bad,
	input  srd_pkg::cmd_t       cmd,
	output srd_pkg::status_t    st
);
	import srd_pkg::*;

	logic [4:0]   radix_q;
	logic [63:0]  digits_low_q;
	logic [63:0]  digits_high_q;
	logic         alpha_ok_q;

	logic [31:0]  mag_q;
	logic         neg_q;
	logic [1:0]   bi_q;
	logic [3:0]   rem_q;
	logic [31:0]  quo_q;
	logic [3:0]   stack_q [STACK_DEPTH];
	logic [5:0]   nd_q;

	logic         out_valid_q;
	logic [7:0]   out_char_q;
	logic         out_last_q;
	logic         out_bad_q;

	logic [127:0] alpha_w;
	logic         alpha_ok_w;
	logic [31:0]  value_u;
	logic [31:0]  mag_load;
	logic [7:0]   byte_w;
	logic [7:0]   qbyte_w;
	logic [3:0]   rem_w;
	logic [31:0]  quo_nx;
	logic [7:0]   dig_char;

	function automatic logic [1:0] top_byte(input logic [31:0] x);
		logic [1:0] idx;
		if (x[31:24] != 8'd0) begin
			idx = 2'd3;
		end else if (x[23:16] != 8'd0) begin
			idx = 2'd2;
		end else if (x[15:8] != 8'd0) begin
			idx = 2'd1;
		end else begin
			idx = 2'd0;
		end
		return idx;
	endfunction

	assign alpha_w = {digits_high_q, digits_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= RADIX_RST;
			digits_low_q  <= DIGITS_LOW_RST;
			digits_high_q <= DIGITS_HIGH_RST;
			alpha_ok_q    <= 1'b1;
		end else begin
			alpha_ok_q <= alpha_ok_w;
			if (cfg_we) begin
				case (cfg_index)
					CFG_RADIX:       radix_q       <= cfg_data[4:0];
					CFG_DIGITS_LOW:  digits_low_q  <= cfg_data;
					CFG_DIGITS_HIGH: digits_high_q <= cfg_data;
					default:         radix_q       <= radix_q;
				endcase
			end
		end
	end

	// Radix range, no sign characters, no repeats among the characters in use.
	always_comb begin
		logic bad;
		bad = (radix_q < 5'd2) || (radix_q > 5'(MAX_RADIX));
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < radix_q) begin
				if (alpha_w[8*i +: 8] == CH_PLUS || alpha_w[8*i +: 8] == CH_MINUS) begin
					bad = 1'b1;
				end
				for (int j = i + 1; j < 16; j++) begin
					if (5'(j) < radix_q && alpha_w[8*j +: 8] == alpha_w[8*i +: 8]) begin
						bad = 1'b1;
					end
				end
			end
		end
		alpha_ok_w = !bad;
	end

	assign value_u  = value;
	assign mag_load = value_u[31] ? (~value_u + 32'd1) : value_u;

	// One dividend byte per cycle: eight restoring steps on a 5-bit remainder.
	always_comb begin
		logic [4:0] t;
		rem_w   = rem_q;
		qbyte_w = 8'd0;
		byte_w  = mag_q[{bi_q, 3'b000} +: 8];
		for (int k = 7; k >= 0; k--) begin
			t = {rem_w, byte_w[k]};
			if (t >= radix_q) begin
				t          = t - radix_q;
				qbyte_w[k] = 1'b1;
			end
			rem_w = t[3:0];
		end
	end

	assign quo_nx = {quo_q[23:0], qbyte_w};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= mag_load;
			neg_q <= value_u[31];
		end
		if (cmd.dig_start) begin
			bi_q  <= top_byte(mag_q);
			rem_q <= 4'd0;
			quo_q <= 32'd0;
		end else if (cmd.div_step) begin
			if (bi_q == 2'd0) begin
				// digit done: quotient becomes the next dividend
				mag_q <= quo_nx;
				bi_q  <= top_byte(quo_nx);
				rem_q <= 4'd0;
				quo_q <= 32'd0;
			end else begin
				bi_q  <= bi_q - 2'd1;
				rem_q <= rem_w;
				quo_q <= quo_nx;
			end
		end
	end

	// Digit stack: entry 0 is the most recent digit, i.e. the next one to send.
	always_ff @(posedge clk) begin
		if (cmd.div_step && bi_q == 2'd0) begin
			stack_q[0] <= rem_w;
			for (int k = 1; k < STACK_DEPTH; k++) begin
				stack_q[k] <= stack_q[k-1];
			end
		end else if (cmd.emit == EM_DIGIT) begin
			for (int k = 0; k < STACK_DEPTH - 1; k++) begin
				stack_q[k] <= stack_q[k+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q <= 6'd0;
		end else if (cmd.load) begin
			nd_q <= 6'd0;
		end else if (cmd.div_step && bi_q == 2'd0) begin
			nd_q <= nd_q + 6'd1;
		end else if (cmd.emit == EM_DIGIT) begin
			nd_q <= nd_q - 6'd1;
		end
	end

	assign dig_char = alpha_w[{stack_q[0], 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != EM_NONE) begin
			out_valid_q <= 1'b1;
		end else if (char_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.emit)
			EM_SIGN: begin
				out_char_q <= CH_MINUS;
				out_last_q <= 1'b0;
				out_bad_q  <= 1'b0;
			end
			EM_DIGIT: begin
				out_char_q <= dig_char;
				out_last_q <= (nd_q == 6'd1);
				out_bad_q  <= 1'b0;
			end
			EM_ERR: begin
				out_char_q <= 8'd0;
				out_last_q <= 1'b1;
				out_bad_q  <= 1'b1;
			end
			default: begin
				out_char_q <= out_char_q;
			end
		endcase
	end

	assign char_valid   = out_valid_q;
	assign out_char     = out_char_q;
	assign last_char    = out_last_q;
	assign alphabet_bad = out_bad_q;

	assign st.alpha_ok    = alpha_ok_q;
	assign st.neg         = neg_q;
	assign st.byte_last   = (bi_q == 2'd0);
	assign st.quo_zero    = (quo_nx == 32'd0);
	assign st.last_digit  = (nd_q == 6'd1);
	assign st.stack_empty = (nd_q == 6'd0);
	assign st.out_free    = !out_valid_q || char_ready;

endmodule

FILE: hw/rtl/signed_integer_to_radix_digits.sv
// Top level of the signed integer to radix digits converter.
// Each accepted value is written out in the configured radix, most significant
// digit first, one character per output word, with '-' ahead of a negative value
// and last_char on the final word. If the radix is below 2 or above 16, or the
// characters in use contain '+', '-' or a repeat, the value gives a single word
// with alphabet_bad set, out_char zero and last_char set. One value at a time is
// converted. For each value the item is accepted, the division started, then the
// byte-serial divider works through each significant byte of the running
// dividend for every digit, retiring eight quotient bits a cycle, and then the
// characters are sent as the receiver takes them. The output word register lets
// the last character wait while the next value is accepted.
module signed_integer_to_radix_digits (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic signed [31:0] value,
	output logic               char_valid,
	input  logic               char_ready,
	output logic [7:0]         out_char,
	output logic               last_char,
	output logic               alphabet_bad
);
	import srd_pkg::*;

	cmd_t    cmd;
	status_t st;

	// Sequencer: decides when to divide and when to send each word.
	srd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	// Datapath: holds config, digits and the output word.
	srd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.value        (value),
		.char_ready   (char_ready),
		.char_valid   (char_valid),
		.out_char     (out_char),
		.last_char    (last_char),
		.alphabet_bad (alphabet_bad),
		.cmd          (cmd),
		.st           (st)
	);

	// Never overwrite a word that is still waiting.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit != EM_NONE |-> st.out_free)
		else $error("word emitted into a full output register");

	// Never pop a digit from an empty stack.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit == EM_DIGIT |-> !st.stack_empty)
		else $error("digit popped from empty stack");

	// The error word is always the only and last one, with a zero character.
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && alphabet_bad |-> last_char && out_char == 8'd0)
		else $error("malformed error word");

	// After a value is taken, no other value is taken in the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("value accepted while busy");

endmodule
